>>> design/tjws_pkg.sv
`timescale 1ns / 1ps
package tjws_pkg;

  localparam int unsigned MAX_WINDOW_DEF = 1048576;

  localparam int TIME_W     = 64;
  localparam int LATE_W     = 32;
  localparam int PERIOD_W   = 32;
  localparam int WLEN_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 32'd100000;
  localparam logic [WLEN_W-1:0]   WINDOW_RST = 21'd10000;
  localparam logic                MODE_RST   = 1'b1;

  localparam logic signed [LATE_W-1:0] MIN_START = 32'sd1000000000;
  localparam logic signed [LATE_W-1:0] MAX_START = -32'sd1000000000;
  localparam logic signed [LATE_W-1:0] LATE_MAX  = 32'sh7fffffff;
  localparam logic signed [LATE_W-1:0] LATE_MIN  = 32'sh80000000;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [WLEN_W-1:0]   window;
    logic                overall;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic late;
    logic accum;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic win_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> design/tjws_if.sv
`timescale 1ns / 1ps
interface tjws_sample_if;
  import tjws_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] observed_time;
  modport source(output valid, output observed_time, input ready);
  modport sink(input valid, input observed_time, output ready);
endinterface

interface tjws_result_if;
  import tjws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [LATE_W-1:0] min_lateness;
  logic signed [LATE_W-1:0] max_lateness;
  logic signed [LATE_W-1:0] mean_lateness;
  modport source(output valid, output min_lateness, output max_lateness,
                 output mean_lateness, input ready);
  modport sink(input valid, input min_lateness, input max_lateness,
               input mean_lateness, output ready);
endinterface

interface tjws_cfg_if;
  import tjws_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> design/tjws_ctrl.sv
`timescale 1ns / 1ps
module tjws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output tjws_pkg::cmd_t    cmd,
  input  tjws_pkg::status_t status
);
  import tjws_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LATE   = 6'b000010,
    S_ACCUM  = 6'b000100,
    S_CHECK  = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LATE;
        end
      end
      S_LATE: begin
        cmd.late   = 1'b1;
        state_next = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.win_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/tjws_datapath.sv
`timescale 1ns / 1ps
module tjws_datapath #(
  parameter int unsigned MAX_WINDOW = tjws_pkg::MAX_WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tjws_pkg::cfg_t                        cfg,
  input  tjws_pkg::cmd_t                        cmd,
  output tjws_pkg::status_t                     status,
  input  logic [tjws_pkg::TIME_W-1:0]           obs_in,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [tjws_pkg::LATE_W-1:0]    out_min,
  output logic signed [tjws_pkg::LATE_W-1:0]    out_max,
  output logic signed [tjws_pkg::LATE_W-1:0]    out_mean
);
  import tjws_pkg::*;

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = LATE_W + 1 + $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int CMP_W = (WIN_W > WLEN_W) ? WIN_W : WLEN_W;

  logic [TIME_W-1:0]        obs;
  logic [TIME_W-1:0]        expected;
  logic signed [LATE_W-1:0] late;
  logic signed [LATE_W-1:0] late_next;
  logic signed [LATE_W-1:0] run_min;
  logic signed [LATE_W-1:0] run_max;
  logic signed [SUM_W-1:0]  sum;
  logic [WIN_W-1:0]         tick;
  logic [WIN_W-1:0]         win;
  logic [CMP_W-1:0]         wl_ext;
  logic [TIME_W-1:0]        diff;

  logic                     neg;
  logic [SUM_W-1:0]         quo;
  logic [WIN_W:0]           rem;
  logic [WIN_W:0]           rem_sh;
  logic                     qbit;
  logic [CNT_W-1:0]         cnt;
  logic signed [SUM_W:0]    mean_wide;
  logic signed [LATE_W-1:0] mean_sat;

  // effective window, clamped to [1, MAX_WINDOW]
  assign wl_ext = CMP_W'(cfg.window);
  always_comb begin
    if (wl_ext == '0) begin
      win = WIN_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = wl_ext[WIN_W-1:0];
    end
  end

  // lateness, saturated to 32 bits
  assign diff = obs - expected;
  always_comb begin
    if (!diff[TIME_W-1] && (|diff[TIME_W-2:LATE_W-1])) begin
      late_next = LATE_MAX;
    end else if (diff[TIME_W-1] && !(&diff[TIME_W-2:LATE_W-1])) begin
      late_next = LATE_MIN;
    end else begin
      late_next = signed'(diff[LATE_W-1:0]);
    end
  end

  // one restoring step
  always_comb begin
    rem_sh = {rem[WIN_W-1:0], quo[SUM_W-1]};
    qbit   = (rem_sh >= {1'b0, win});
  end

  // signed mean, saturated
  always_comb begin
    mean_wide = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    if (!mean_wide[SUM_W] && (|mean_wide[SUM_W-1:LATE_W-1])) begin
      mean_sat = LATE_MAX;
    end else if (mean_wide[SUM_W] && !(&mean_wide[SUM_W-1:LATE_W-1])) begin
      mean_sat = LATE_MIN;
    end else begin
      mean_sat = signed'(mean_wide[LATE_W-1:0]);
    end
  end

  assign status.win_done = (tick >= win);
  assign status.div_done = (cnt == CNT_W'(SUM_W));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
      run_min  <= MIN_START;
      run_max  <= MAX_START;
      sum      <= '0;
      tick     <= '0;
    end else begin
      if (cmd.load) begin
        expected <= expected + TIME_W'(cfg.period);
      end
      if (cmd.accum) begin
        if (late < run_min) begin
          run_min <= late;
        end
        if (late > run_max) begin
          run_max <= late;
        end
        sum  <= sum + SUM_W'(late);
        tick <= tick + WIN_W'(1);
      end
      if (cmd.finish) begin
        sum  <= '0;
        tick <= '0;
        if (!cfg.overall) begin
          run_min <= MIN_START;
          run_max <= MAX_START;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obs <= obs_in;
    end
    if (cmd.late) begin
      late <= late_next;
    end
    if (cmd.div_start) begin
      neg <= sum[SUM_W-1];
      quo <= sum[SUM_W-1] ? unsigned'(-sum) : unsigned'(sum);
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? (rem_sh - {1'b0, win}) : rem_sh;
      quo <= {quo[SUM_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_start) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_min  <= run_min;
      out_max  <= run_max;
      out_mean <= mean_sat;
    end
  end

endmodule

>>> design/timer_jitter_window_statistics.sv
`timescale 1ns / 1ps
// Periodic wake-up latency statistics. Each sample word carries the observed
// timer count of one wake-up; the block advances its expected time by the
// period, takes the saturated lateness and tracks minimum, maximum and sum.
// After window_length wake-ups one result word gives min, max and the mean
// truncated toward zero, all in timer counts. A wake-up that does not close
// a window passes through the controller steps expected time, lateness,
// accumulate and window check. A wake-up that closes a window then runs
// the bit-serial restoring divider and waits while the previous result
// word is still held at the output register. A new sample word is taken
// only once the previous wake-up is finished.
// Configuration writes are taken in any cycle, one per cycle.
module timer_jitter_window_statistics #(
  parameter int unsigned MAX_WINDOW = tjws_pkg::MAX_WINDOW_DEF
) (
  input logic           clk,
  input logic           rst,
  tjws_sample_if.sink   sample,
  tjws_result_if.source result,
  tjws_cfg_if.sink      cfg
);
  import tjws_pkg::*;

  cfg_t    cfg_regs;
  cmd_t    cmd;
  status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.period  <= PERIOD_RST;
      cfg_regs.window  <= WINDOW_RST;
      cfg_regs.overall <= MODE_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PERIOD: cfg_regs.period  <= cfg.data[PERIOD_W-1:0];
        REG_WINDOW: cfg_regs.window  <= cfg.data[WLEN_W-1:0];
        REG_MODE:   cfg_regs.overall <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  tjws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .cmd      (cmd),
    .status   (status)
  );

  tjws_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .cmd       (cmd),
    .status    (status),
    .obs_in    (sample.observed_time),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_min   (result.min_lateness),
    .out_max   (result.max_lateness),
    .out_mean  (result.mean_lateness)
  );

  // one wake-up at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample taken while previous wake-up in progress");

  // a pending result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result.valid)
    else $error("finished window not presented");

  a_div_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sample.ready && !cmd.accum)
    else $error("divider running alongside accumulation");

endmodule
